// ----- rtl/core/srs_pkg.sv -----
package srs_pkg;

  localparam int CNT_W = 20;   // period counter and integration register
  localparam int ADC_W = 16;
  localparam int IDX_W = 9;

  localparam logic [CNT_W-1:0] INTEG_RESET = 20'd1000;

  // one result item per half period
  typedef struct packed {
    logic             busy;
    logic             pixel_last;
    logic [ADC_W-1:0] pixel_value;
    logic [IDX_W-1:0] pixel_index;
    logic             pixel_valid;
    logic             sensor_start;
    logic             sensor_clock;
  } res_t;

endpackage

// ----- rtl/core/srs_timing.sv -----
module srs_timing import srs_pkg::*; #(
  parameter int PIXEL_COUNT = 288,
  parameter int TAIL_CLOCKS = 87,
  parameter int LEAD_CLOCKS = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  logic             start_request,
  input  logic [ADC_W-1:0] adc_value,
  input  logic [CNT_W-1:0] integration_cycles,
  output res_t             res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_LEAD  = 3'd2,
    PH_INTEG = 3'd3,
    PH_TAIL  = 3'd4,
    PH_PIX   = 3'd5
  } phase_t;

  localparam logic [CNT_W-1:0] LEAD_LIM  = CNT_W'(LEAD_CLOCKS);
  localparam logic [CNT_W-1:0] TAIL_LIM  = CNT_W'(TAIL_CLOCKS);
  localparam logic [CNT_W-1:0] PIX_LIM   = CNT_W'(PIXEL_COUNT);
  localparam logic [CNT_W-1:0] PIX_FINAL = CNT_W'(PIXEL_COUNT - 1);
  localparam logic [CNT_W-1:0] PRE_LEN   = CNT_W'(3);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] period_count, period_count_next;
  logic             half_period, half_period_next;
  logic             clock_level, clock_level_next;
  logic             start_level, start_level_next;

  always_comb begin
    phase_t           ph;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] limit;
    logic             hp;
    logic             go;
    logic             clk_lvl;
    logic             st_lvl;

    ph      = phase;
    cnt     = period_count;
    hp      = half_period;
    go      = 1'b1;
    clk_lvl = clock_level;
    st_lvl  = start_level;
    limit   = PIX_LIM;

    phase_next        = phase;
    period_count_next = period_count;
    half_period_next  = half_period;

    res              = '0;
    res.sensor_clock = clock_level;
    res.sensor_start = start_level;

    // idle, or an undefined code: a request starts the preamble on this tick
    case (phase)
      PH_PRE, PH_LEAD, PH_INTEG, PH_TAIL, PH_PIX: ;
      default: begin
        phase_next = PH_IDLE;
        if (start_request) begin
          ph  = PH_PRE;
          cnt = '0;
          hp  = 1'b0;
        end else begin
          go = 1'b0;
        end
      end
    endcase

    cnt_inc = cnt + 1'b1;

    if (go) begin
      res.busy = 1'b1;
      if (ph == PH_PRE) begin
        // low, high, low with start rising
        clk_lvl = (cnt == CNT_W'(1));
        st_lvl  = (cnt >= CNT_W'(2));
        if (cnt_inc >= PRE_LEN) begin
          phase_next        = PH_LEAD;
          period_count_next = '0;
          half_period_next  = 1'b0;
        end else begin
          phase_next        = PH_PRE;
          period_count_next = cnt_inc;
          half_period_next  = hp;
        end
      end else begin
        clk_lvl = !hp;
        st_lvl  = (ph == PH_LEAD) || (ph == PH_INTEG);
        if (ph == PH_PIX && !hp) begin
          res.pixel_valid = 1'b1;
          res.pixel_index = cnt[IDX_W-1:0];
          res.pixel_value = adc_value;
          res.pixel_last  = (cnt >= PIX_FINAL);
        end
        case (ph)
          PH_LEAD:  limit = LEAD_LIM;
          PH_INTEG: limit = integration_cycles;
          PH_TAIL:  limit = TAIL_LIM;
          default:  limit = PIX_LIM;
        endcase
        phase_next = ph;
        if (!hp) begin
          half_period_next  = 1'b1;
          period_count_next = cnt;
        end else begin
          half_period_next = 1'b0;
          if (cnt_inc >= limit) begin
            period_count_next = '0;
            case (ph)
              PH_LEAD:  phase_next = (integration_cycles == '0) ? PH_TAIL : PH_INTEG;
              PH_INTEG: phase_next = PH_TAIL;
              PH_TAIL:  phase_next = PH_PIX;
              default:  phase_next = PH_IDLE;
            endcase
          end else begin
            period_count_next = cnt_inc;
          end
        end
      end
      res.sensor_clock = clk_lvl;
      res.sensor_start = st_lvl;
    end

    clock_level_next = clk_lvl;
    start_level_next = st_lvl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      period_count <= '0;
      half_period  <= 1'b0;
      clock_level  <= 1'b1;
      start_level  <= 1'b0;
    end else if (step_en) begin
      phase        <= phase_next;
      period_count <= period_count_next;
      half_period  <= half_period_next;
      clock_level  <= clock_level_next;
      start_level  <= start_level_next;
    end
  end

  // start is never left high outside a frame
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    !res.busy |-> !res.sensor_start)
    else $error("start high while idle");

  // pixels are captured on the high half only
  a_pix_clk: assert property (@(posedge clk) disable iff (rst)
    res.pixel_valid |-> res.sensor_clock && !half_period)
    else $error("pixel outside high half period");

  // a final pixel ends the frame: next step sees the low half, then idle
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    step_en && res.pixel_last |=> phase == PH_PIX && half_period)
    else $error("final pixel not followed by closing half period");

  // preamble never uses the half-period toggle
  a_pre_hp: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PRE |-> !half_period)
    else $error("half period set in preamble");

endmodule

// ----- rtl/core/spectrometer_readout_sequencer_top.sv -----
// An input transaction passes the input reg, then the result reg, to a result transaction
//   on m_axis; while m_axis holds a result back, the step and the input reg stall.
// Throughput: one input per cycle unless stalled; each item is one sensor half period,
//   stepped by a single pass through the timing logic between the two registers.
// Reset (rst, sync, active high): idle, clock level high, start low, both regs empty,
//   integration_cycles = 1000.
module spectrometer_readout_sequencer_top import srs_pkg::*; #(
  parameter int PIXEL_COUNT = 288,
  parameter int TAIL_CLOCKS = 87,
  parameter int LEAD_CLOCKS = 7
) (
  input  logic             clk,
  input  logic             rst,
  // slave side
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // [0] start_request, [16:1] adc_value, pad
  // master side
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [0] sensor_clock, [1] sensor_start,
                                           // [2] pixel_valid, [11:3] pixel_index,
                                           // [27:12] pixel_value, [28] busy_res, pad
  output logic             m_axis_tlast,   // pixel_last
  // integration_cycles write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  logic             in_valid;
  logic             in_req;
  logic [ADC_W-1:0] in_adc;
  logic             out_valid;
  res_t             out_res;
  res_t             step_res;
  logic             step_en;
  logic [CNT_W-1:0] integration_cycles;

  // step whenever an item waits and the result slot is free or draining
  assign step_en       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step_en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_cycles <= INTEG_RESET;
    end else if (cfg_valid) begin
      integration_cycles <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req <= s_axis_tdata[0];
      in_adc <= s_axis_tdata[16:1];
    end
  end

  srs_timing #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .TAIL_CLOCKS (TAIL_CLOCKS),
    .LEAD_CLOCKS (LEAD_CLOCKS)
  ) u_timing (
    .clk                (clk),
    .rst                (rst),
    .step_en            (step_en),
    .start_request      (in_req),
    .adc_value          (in_adc),
    .integration_cycles (integration_cycles),
    .res                (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.pixel_last;
  assign m_axis_tdata  = {3'b000, out_res.busy, out_res.pixel_value, out_res.pixel_index,
                          out_res.pixel_valid, out_res.sensor_start, out_res.sensor_clock};

endmodule

// ----- bench/spectrometer_readout_sequencer_top_test.sv -----
module spectrometer_readout_sequencer_top_test;
  import srs_pkg::*;

  // sensor geometry, kept equal to the defaults of the block
  localparam int PIXELS = 288;
  localparam int TAIL = 87;
  localparam int LEAD = 7;

  localparam int HOLD_LONG = 400;          // receiver hold-off that backs up the pipe
  localparam int SETTLE = 6;               // cycles past the last result before a cfg write
  localparam longint LIMIT = 1_200_000;    // watchdog, in clock cycles

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_LEAD,
    ST_INTEG,
    ST_TAIL,
    ST_PIX
  } seq_phase_t;

  // Tracks the sequencer timing and holds the levels still owed on m_axis.
  class readout_tracker;
    logic [CNT_W-1:0] integ_len;
    seq_phase_t       phase;
    logic [CNT_W-1:0] count;
    bit               half;
    bit               clk_lvl;
    bit               start_lvl;
    res_t             owed_ticks[$];
    int               errors;

    function new();
      integ_len = INTEG_RESET;
      phase = ST_IDLE;
      count = '0;
      half = 0;
      clk_lvl = 1;
      start_lvl = 0;
      errors = 0;
    endfunction

    function bit is_idle();
      return phase == ST_IDLE;
    endfunction

    function int outstanding();
      return owed_ticks.size();
    endfunction

    // one sensor half period
    function res_t next_levels(bit req, logic [ADC_W-1:0] adc);
      res_t        r;
      int unsigned lim;
      r = '0;
      if (phase == ST_IDLE) begin
        if (!req) begin
          // idle: repeat the last levels driven
          r.sensor_clock = clk_lvl;
          r.sensor_start = start_lvl;
          return r;
        end
        phase = ST_PRE;
        count = '0;
        half = 0;
      end
      r.busy = 1;
      if (phase == ST_PRE) begin
        r.sensor_clock = (count == 1);
        r.sensor_start = (count >= 2);
        count = count + 1'b1;
        if (count >= 3) begin
          phase = ST_LEAD;
          count = '0;
          half = 0;
        end
      end else begin
        r.sensor_clock = !half;
        r.sensor_start = (phase == ST_LEAD || phase == ST_INTEG);
        if (phase == ST_PIX && !half) begin
          r.pixel_valid = 1;
          r.pixel_index = count[IDX_W-1:0];
          r.pixel_value = adc;
          r.pixel_last  = (32'(count) + 32'd1 >= PIXELS);
        end
        if (!half) begin
          half = 1;
        end else begin
          half = 0;
          count = count + 1'b1;
          case (phase)
            ST_LEAD:  lim = LEAD;
            ST_INTEG: lim = 32'(integ_len);
            ST_TAIL:  lim = TAIL;
            default:  lim = PIXELS;
          endcase
          if (count >= lim) begin
            count = '0;
            case (phase)
              ST_LEAD:  phase = (integ_len == 0) ? ST_TAIL : ST_INTEG;
              ST_INTEG: phase = ST_TAIL;
              ST_TAIL:  phase = ST_PIX;
              default:  phase = ST_IDLE;
            endcase
          end
        end
      end
      clk_lvl = r.sensor_clock;
      start_lvl = r.sensor_start;
      return r;
    endfunction

    function void take_tick(bit req, logic [ADC_W-1:0] adc);
      owed_ticks.push_back(next_levels(req, adc));
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_tick(logic [31:0] data, logic last);
      res_t want;
      if (owed_ticks.size() == 0) begin
        $error("unexpected result transaction: tdata=%h tlast=%b", data, last);
        errors++;
        return;
      end
      want = owed_ticks.pop_front();
      match("sensor_clock", 32'(want.sensor_clock), 32'(data[0]));
      match("sensor_start", 32'(want.sensor_start), 32'(data[1]));
      match("pixel_valid", 32'(want.pixel_valid), 32'(data[2]));
      match("pixel_index", 32'(want.pixel_index), 32'(data[11:3]));
      match("pixel_value", 32'(want.pixel_value), 32'(data[27:12]));
      match("busy_res", 32'(want.busy), 32'(data[28]));
      match("pixel_last", 32'(want.pixel_last), 32'(last));
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  readout_tracker book = new();

  bit     src_calm = 0;       // no sender gaps
  bit     sink_calm = 0;      // no receiver stalls
  bit     long_hold_req = 0;  // ask the receiver for one long hold-off
  int     sink_hold = 0;
  longint cycle_count = 0;

  spectrometer_readout_sequencer_top #(
    .PIXEL_COUNT(PIXELS),
    .TAIL_CLOCKS(TAIL),
    .LEAD_CLOCKS(LEAD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),    // [0] start_request, [16:1] adc_value, pad
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),    // [0] clock, [1] start, [2] pixel_valid, [11:3] index,
                                    // [27:12] value, [28] busy_res, pad
    .m_axis_tlast(m_axis_tlast),    // pixel_last
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request, counted here
  // so the sender keeps pushing meanwhile.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      sink_hold = HOLD_LONG;
    end
    if (sink_hold > 0) begin
      m_axis_tready <= 0;
      sink_hold--;
    end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 0;
      sink_hold = $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1;
    end
  end

  // every accepted result transaction is checked against the oldest owed tick
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_tick(m_axis_tdata, m_axis_tlast);
  end

  // Offer one half-period item; returns once the transaction is taken.
  // Inputs move on the falling edge, the handshake is seen on the rising one.
  task automatic offer_tick(bit req, logic [ADC_W-1:0] adc);
    @(negedge clk);
    if (!src_calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'b0, adc, req};
    do @(posedge clk); while (!s_axis_tready);
    book.take_tick(req, adc);
  endtask

  // Stop offering, wait for every owed result, then let the pipe go quiet.
  task automatic drain_all();
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called with the pipe drained
  task automatic write_integration(logic [CNT_W-1:0] len);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    book.integ_len = len;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Finish the running frame. Requests stay high, so the final tick of the
  // frame also carries one that must be ignored.
  task automatic run_to_idle();
    while (!book.is_idle()) offer_tick(1'b1, 16'($urandom));
  endtask

  // Random ticks: while idle a frame request comes now and then, while busy
  // requests come at random and are ignored.
  task automatic random_ticks(int count);
    bit req;
    repeat (count) begin
      req = book.is_idle() ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 1) == 1);
      offer_tick(req, 16'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: idle levels after reset, converter extremes
    offer_tick(1'b0, 16'h0000);
    offer_tick(1'b0, 16'hFFFF);
    offer_tick(1'b0, 16'h5555);

    // frame started at the reset length; requests keep arriving while busy
    offer_tick(1'b1, 16'hAAAA);
    for (int k = 0; k < 8; k++) offer_tick(1'b1, k[0] ? 16'hFFFF : 16'h0000);

    // pipe drained inside the lead clocks: a zero length skips integration,
    // and the receiver backs up the pipe for a long stretch
    drain_all();
    write_integration('0);
    long_hold_req = 1;
    run_to_idle();
    offer_tick(1'b0, 16'hFFFF);   // idle after a frame: clock low, start low

    // all-ones length: written, but only idle ticks follow
    drain_all();
    write_integration({CNT_W{1'b1}});
    repeat (12) offer_tick(1'b0, 16'($urandom));

    // second frame runs into integration, then the sender pauses until every
    // result is back and the length is cut below the running count
    drain_all();
    write_integration(20'd40);
    offer_tick(1'b1, 16'($urandom));
    repeat (46) offer_tick($urandom_range(0, 1) == 1, 16'($urandom));
    drain_all();
    write_integration(20'd6);

    // last stretch with no gaps and no stalls: tail and part of the pixels
    src_calm = 1;
    sink_calm = 1;
    random_ticks(320);

    drain_all();
    if (book.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/srs_pkg.sv
rtl/core/srs_timing.sv
rtl/core/spectrometer_readout_sequencer_top.sv
bench/spectrometer_readout_sequencer_top_test.sv
